/* rtl/kee_pkg.sv */
// Package for the keypad expression evaluator.
// Holds key codes, operator and status codes and the expression length limit.
// No dependencies.
package kee_pkg;

  localparam int MAX_CHARS = 16;
  localparam int CNT_W     = 5;

  localparam logic [7:0] KEY_EQ    = 8'h3D;  // '='
  localparam logic [7:0] KEY_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] KEY_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] KEY_MUL   = 8'h58;  // 'X'
  localparam logic [7:0] KEY_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] KEY_ADD   = 8'h2B;  // '+'

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_MATH   = 2'd2;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

endpackage

/* rtl/keypad_expression_evaluator_unit.sv */
// Keypad expression evaluator: left-to-right integer calculator.
// Takes one key word per item and gives one result word per expression.
// Channels: in_valid/in_ready carry in_key_char; out_valid/out_ready carry
// out_answer and out_status (0 ok, 1 syntax error, 2 divide by zero).
// A digit is taken in the idle state alone, so digits can follow back to back
// until the sixteenth key. '=' and the operator keys apply the pending operator:
// '+' and '-' through the ALU state, 'X' and '/' through the MUL or DIV state,
// where they drive a shared 18-bit adder through sixteen shift-add or
// restoring-divide steps. An '=' that needs no evaluation goes from accept
// straight to the finish state; any other key that ends the expression
// passes through the finish state after its evaluation.
// An expression ends at '=' or at its sixteenth key, and its result is loaded
// into an output register from the finish state once evaluation completes.
// The output register holds the word until the receiver takes it; a new key
// is still accepted meanwhile, but a following result waits in the finish
// state, with in_ready low, until the register is free.
// Reset (rst_n low, synchronous) clears the expression state and drops
// out_valid; in_ready is high in the first cycle after reset.
module keypad_expression_evaluator_unit
  import kee_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_key_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_answer,
  output logic [1:0]         out_status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALU  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [15:0]      cur_r, cur_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic             last_r, last_nxt;
  logic             syn_r, syn_nxt;
  logic             math_r, math_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fin_r, fin_nxt;
  logic             sub_r, sub_nxt;
  logic             neg_r, neg_nxt;
  logic [15:0]      opnd_r, opnd_nxt;
  logic [15:0]      work_r, work_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [3:0]       step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_answer_r, out_answer_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  // Shared adder/subtractor used by every ALU, multiply and divide step.
  logic [16:0] alu_a, alu_b;
  logic        alu_sub;
  logic [17:0] alu_res;

  logic             accept;
  logic             key_is_op;
  logic [1:0]       key_op;
  logic [CNT_W-1:0] cnt_inc;
  logic             hit;
  logic [15:0]      digit_val;
  logic             do_apply;
  logic [15:0]      b_val;
  logic             fin_now;
  logic [15:0]      acc_mag, b_mag, quot;
  logic             qbit;

  assign accept = in_valid && in_ready;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_ALU: begin
        alu_a   = {1'b0, acc_r};
        alu_b   = {1'b0, opnd_r};
        alu_sub = sub_r;
      end
      S_MUL: begin
        alu_a = {1'b0, rem_r};
        alu_b = {1'b0, work_r};
      end
      S_DIV: begin
        alu_a   = {rem_r, work_r[15]};
        alu_b   = {1'b0, opnd_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  always_comb begin
    unique case (in_key_char)
      KEY_DIV: begin key_is_op = 1'b1; key_op = OP_DIV; end
      KEY_MUL: begin key_is_op = 1'b1; key_op = OP_MUL; end
      KEY_SUB: begin key_is_op = 1'b1; key_op = OP_SUB; end
      KEY_ADD: begin key_is_op = 1'b1; key_op = OP_ADD; end
      default: begin key_is_op = 1'b0; key_op = OP_ADD; end
    endcase
  end

  assign cnt_inc   = cnt_r + 1'b1;
  assign hit       = (cnt_inc >= MAX_CNT);
  // Ten times the number is eight times plus twice; any other code counts as a digit.
  assign digit_val = (cur_r << 3) + (cur_r << 1) + ({8'h00, in_key_char} - {8'h00, KEY_ZERO});
  assign qbit      = !alu_res[17];
  assign quot      = {work_r[14:0], qbit};

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    cur_nxt        = cur_r;
    pend_nxt       = pend_r;
    last_nxt       = last_r;
    syn_nxt        = syn_r;
    math_nxt       = math_r;
    cnt_nxt        = cnt_r;
    fin_nxt        = fin_r;
    sub_nxt        = sub_r;
    neg_nxt        = neg_r;
    opnd_nxt       = opnd_r;
    work_nxt       = work_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;
    out_answer_nxt = out_answer_r;
    out_status_nxt = out_status_r;
    do_apply       = 1'b0;
    b_val          = cur_r;
    fin_now        = 1'b0;
    acc_mag        = acc_r[15] ? (16'd0 - acc_r) : acc_r;
    b_mag          = 16'd0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_key_char == KEY_EQ) begin
            fin_now = 1'b1;
            if (last_r) begin
              syn_nxt = 1'b1;
            end else begin
              do_apply = 1'b1;
            end
          end else if (key_is_op) begin
            if (last_r) begin
              syn_nxt = 1'b1;
            end else begin
              do_apply = 1'b1;
              pend_nxt = key_op;
              cur_nxt  = 16'd0;
            end
            last_nxt = 1'b1;
            cnt_nxt  = cnt_inc;
            fin_now  = hit;
            // An operator as the last key of a full expression is a trailing operator.
            if (hit) begin
              syn_nxt = 1'b1;
            end
          end else begin
            cur_nxt  = digit_val;
            b_val    = digit_val;
            last_nxt = 1'b0;
            cnt_nxt  = cnt_inc;
            fin_now  = hit;
            do_apply = hit;
          end
          fin_nxt   = fin_now;
          state_nxt = fin_now ? S_DONE : S_IDLE;
          // An earlier error skips every later evaluation.
          if (do_apply && !syn_r && !math_r) begin
            b_mag    = b_val[15] ? (16'd0 - b_val) : b_val;
            opnd_nxt = b_val;
            rem_nxt  = 16'd0;
            step_nxt = 4'd0;
            unique case (pend_r)
              OP_ADD, OP_SUB: begin
                sub_nxt   = (pend_r == OP_SUB);
                state_nxt = S_ALU;
              end
              OP_MUL: begin
                work_nxt  = acc_r;
                state_nxt = S_MUL;
              end
              default: begin
                if (b_val == 16'd0) begin
                  math_nxt = 1'b1;
                end else begin
                  work_nxt  = acc_mag;
                  opnd_nxt  = b_mag;
                  neg_nxt   = acc_r[15] ^ b_val[15];
                  state_nxt = S_DIV;
                end
              end
            endcase
          end
        end
      end
      S_ALU: begin
        acc_nxt   = alu_res[15:0];
        state_nxt = fin_r ? S_DONE : S_IDLE;
      end
      S_MUL: begin
        if (opnd_r[0]) begin
          rem_nxt = alu_res[15:0];
        end
        work_nxt = work_r << 1;
        opnd_nxt = opnd_r >> 1;
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd15) begin
          acc_nxt   = opnd_r[0] ? alu_res[15:0] : rem_r;
          state_nxt = fin_r ? S_DONE : S_IDLE;
        end
      end
      S_DIV: begin
        rem_nxt  = qbit ? alu_res[15:0] : {rem_r[14:0], work_r[15]};
        work_nxt = quot;
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd15) begin
          acc_nxt   = neg_r ? (16'd0 - quot) : quot;
          state_nxt = fin_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          priority if (syn_r) begin
            out_status_nxt = ST_SYNTAX;
            out_answer_nxt = 16'd0;
          end else if (math_r) begin
            out_status_nxt = ST_MATH;
            out_answer_nxt = 16'd0;
          end else begin
            out_status_nxt = ST_OK;
            out_answer_nxt = acc_r;
          end
          acc_nxt   = 16'd0;
          cur_nxt   = 16'd0;
          pend_nxt  = OP_ADD;
          last_nxt  = 1'b0;
          syn_nxt   = 1'b0;
          math_nxt  = 1'b0;
          cnt_nxt   = '0;
          fin_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= 16'd0;
      cur_r       <= 16'd0;
      pend_r      <= OP_ADD;
      last_r      <= 1'b0;
      syn_r       <= 1'b0;
      math_r      <= 1'b0;
      cnt_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cur_r       <= cur_nxt;
      pend_r      <= pend_nxt;
      last_r      <= last_nxt;
      syn_r       <= syn_nxt;
      math_r      <= math_nxt;
      cnt_r       <= cnt_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sub_r        <= sub_nxt;
    neg_r        <= neg_nxt;
    opnd_r       <= opnd_nxt;
    work_r       <= work_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    out_answer_r <= out_answer_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;
  assign out_status = out_status_r;

`ifndef NO_ASSERTIONS
  // An error word always carries a zero answer.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_answer == 16'sd0))
    else $error("error word with non-zero answer");

  // While keys are taken, the key count stays below the expression limit.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cnt_r < MAX_CNT))
    else $error("key count out of range");

  // No key is taken while a multiply or divide loop runs.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DIV) |-> !in_ready)
    else $error("ready during arithmetic loop");

  // A word is loaded only when leaving the finish state.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside finish state");
`endif

endmodule
